FILE: hdl/mstb_pkg.sv
// Package for the timer bank: opcodes, result kinds, controller state and
// the command and status bundles between controller and datapath. No dependencies.
`default_nettype none

package mstb_pkg;

  localparam int VALUE_W = 16;
  localparam int TIME_W  = 17;

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_START_ONE = 2'd1;
  localparam logic [1:0] OP_START_PER = 2'd2;
  localparam logic [1:0] OP_STOP      = 2'd3;

  localparam logic [1:0] EV_START  = 2'd0;
  localparam logic [1:0] EV_STOP   = 2'd1;
  localparam logic [1:0] EV_EXPIRE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec_op;
    logic scan_init;
    logic scan_step;
    logic flush_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic out_free;
    logic slot_fire;
    logic scan_last;
    logic pend_valid;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/mstb_ctrl.sv
// Controller for the timer bank: sequences capture, start/stop execution,
// the tick scan and the final flush. Depends on mstb_pkg.
`default_nettype none

module mstb_ctrl import mstb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state, state_next;
  logic   hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a second expiry cannot be taken while the first still waits for the output
  assign hold = sts.slot_fire && sts.pend_valid && !sts.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op_tick) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else if (sts.out_free) begin
          cmd.exec_op = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!hold) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/mstb_datapath.sv
// Datapath for the timer bank: slot masks, per-slot time stores, tick period,
// scan index, pending expiry and the output register. Depends on mstb_pkg.
`default_nettype none

module mstb_datapath import mstb_pkg::*; #(
  parameter int TIMER_COUNT = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_sts_t               sts,
  input  wire logic [1:0]         opcode,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [7:0]         slot_id,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [VALUE_W-1:0] cfg_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              event_kind,
  output logic [3:0]              slot,
  output logic                    ok,
  output logic                    last
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  logic [1:0]               op_r;
  logic [VALUE_W-1:0]       val_r;
  logic [7:0]               sid_r;
  logic [VALUE_W-1:0]       tick_period;
  logic [TIMER_COUNT-1:0]   active;
  logic [TIMER_COUNT-1:0]   periodic;
  logic signed [TIME_W-1:0] remaining [TIMER_COUNT];
  logic [VALUE_W-1:0]       reload [TIMER_COUNT];
  logic [IW-1:0]            idx;
  logic [IW-1:0]            pend_slot;
  logic                     pend_valid;

  logic                     out_free;
  logic [IW-1:0]            free_idx;
  logic                     free_found;
  logic                     start_ok;
  logic                     stop_ok;
  logic signed [TIME_W-1:0] diff;
  logic                     expires;
  logic                     fire;
  logic [7:0]               pend8;
  logic [7:0]               free8;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_idx   = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign start_ok = (val_r != '0) && free_found;
  assign stop_ok  = {1'b0, sid_r} < 9'(TIMER_COUNT);
  assign diff     = remaining[idx] - $signed({1'b0, tick_period});
  assign expires  = diff[TIME_W-1] || (diff == '0);
  assign fire     = active[idx] && expires;
  assign pend8    = 8'(pend_slot);
  assign free8    = 8'(free_idx);

  assign sts.op_tick    = (op_r == OP_TICK);
  assign sts.out_free   = out_free;
  assign sts.slot_fire  = fire;
  assign sts.scan_last  = (idx == IW'(TIMER_COUNT - 1));
  assign sts.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= opcode;
      val_r <= value;
      sid_r <= slot_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= VALUE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      tick_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      periodic   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec_op) begin
        out_valid <= 1'b1;
        last      <= 1'b1;
        if (op_r == OP_STOP) begin
          event_kind <= EV_STOP;
          ok         <= stop_ok;
          slot       <= stop_ok ? sid_r[3:0] : 4'd0;
          if (stop_ok) begin
            active[sid_r[IW-1:0]] <= 1'b0;
          end
        end else begin
          event_kind <= EV_START;
          ok         <= start_ok;
          slot       <= start_ok ? free8[3:0] : 4'd0;
          if (start_ok) begin
            active[free_idx] <= 1'b1;
            if (op_r == OP_START_PER) begin
              periodic[free_idx]  <= 1'b1;
              reload[free_idx]    <= val_r;
              remaining[free_idx] <= '0;
            end else begin
              periodic[free_idx]  <= 1'b0;
              reload[free_idx]    <= '0;
              remaining[free_idx] <= $signed({1'b0, val_r});
            end
          end
        end
      end
      if (cmd.scan_init) begin
        idx        <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx <= idx + IW'(1);
        if (active[idx]) begin
          if (!expires) begin
            remaining[idx] <= diff;
          end else begin
            if (periodic[idx]) begin
              remaining[idx] <= $signed({1'b0, reload[idx]});
            end else begin
              active[idx] <= 1'b0;
            end
            if (pend_valid) begin
              out_valid  <= 1'b1;
              event_kind <= EV_EXPIRE;
              slot       <= pend8[3:0];
              ok         <= 1'b0;
              last       <= 1'b0;
            end
            pend_slot  <= idx;
            pend_valid <= 1'b1;
          end
        end
      end
      if (cmd.flush_emit) begin
        out_valid  <= 1'b1;
        event_kind <= EV_EXPIRE;
        slot       <= pend8[3:0];
        ok         <= 1'b0;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/multi_slot_soft_timer_bank.sv
// Top level of the timer bank: joins controller and datapath.
// Depends on mstb_pkg, mstb_ctrl and mstb_datapath.
//
// A start or stop item is captured in the idle state; its reply is loaded
// into the output register from the execute state once the output is free,
// and the bank returns to idle for the next item. A tick walks the slots one
// per cycle through a single subtract-and-compare unit, pausing while a
// second expiry waits on a stalled output; the flush state then loads the
// last pending expiry, if any, and the bank is idle again. The expiry list
// is held back by one entry so that the final result can carry last. One
// item is in work at a time; the input is stalled until it finishes, but a
// new item is taken while the last result still sits in the output register.
// tick_period may be written at any time the bank is idle; cfg_ready is
// always high.
`default_nettype none

module multi_slot_soft_timer_bank import mstb_pkg::*; #(
  parameter int TIMER_COUNT = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [7:0]         slot_id,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              event_kind,
  output logic [3:0]              slot,
  output logic                    ok,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [VALUE_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  mstb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mstb_datapath #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .value      (value),
    .slot_id    (slot_id),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .slot       (slot),
    .ok         (ok),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: hdl/mstb_checker.sv
// Port-level checks for the timer bank and the bind that attaches them.
// Depends on mstb_pkg and multi_slot_soft_timer_bank.
`default_nettype none

module mstb_checker import mstb_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] event_kind,
  input wire logic [3:0] slot,
  input wire logic       ok,
  input wire logic       last
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(slot)
      && $stable(ok) && $stable(last))
    else $error("output changed while stalled");

  // start and stop give a single reply
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_START || event_kind == EV_STOP) |-> last)
    else $error("reply without last");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok && (event_kind == EV_START || event_kind == EV_STOP) |-> slot == 4'd0)
    else $error("failed reply with nonzero slot");

  a_expire_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_EXPIRE |-> !ok)
    else $error("expiry with ok set");

endmodule

bind multi_slot_soft_timer_bank mstb_checker u_mstb_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .event_kind (event_kind),
  .slot       (slot),
  .ok         (ok),
  .last       (last)
);

`default_nettype wire
